// ===== rtl/diamond_square_heightmap_defines.svh =====
// Assertion macros used by the height map RTL.
`ifndef DIAMOND_SQUARE_HEIGHTMAP_DEFINES_SVH
`define DIAMOND_SQUARE_HEIGHTMAP_DEFINES_SVH

// Checks a consequence in the same cycle as its antecedent.
`define DSH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks a consequence in the cycle after its antecedent.
`define DSH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dsh_pkg.sv =====
// Shared constants, action codes and helpers of the height map generator.
package dsh_pkg;

  localparam int HEIGHT_W        = 16;
  localparam int RAND_W          = 8;
  localparam int COORD_IN_W      = 7;
  localparam int GRID_SIZE_DEF   = 65;
  localparam int QUEUE_DEPTH_DEF = 1024;
  localparam int SCALE_Q16       = 38968;

  localparam logic [1:0] ACT_STEP    = 2'd0;
  localparam logic [1:0] ACT_READ    = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;

  localparam logic CFG_MIN = 1'b0;
  localparam logic CFG_MAX = 1'b1;

  // Clamps a wide signed value into the signed 16-bit height range.
  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    logic signed [15:0] res;
    if (v > 20'sd32767) begin
      res = 16'sh7fff;
    end else if (v < -20'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = 16'(v);
    end
    return res;
  endfunction

endpackage

// ===== rtl/diamond_square_heightmap.sv =====
// Top level: diamond-square height map generator around a grid and a region queue memory.
// Step: queue pop, four corner reads, five read-modify-write point updates, then four
// pushes when the region splits. A read inside the grid adds a grid read; a restart clears
// the grid, writes the four corners and seeds the queue. Any other request answers directly.
// One request at a time; the next is taken only after the result of the last is registered.
// Reset (rst_n low, synchronous) empties the queue and starts a clearing pass over all
// GRID_SIZE*GRID_SIZE points that zeroes the grid; no request is taken until it ends.
module diamond_square_heightmap #(
  parameter int GRID_SIZE   = dsh_pkg::GRID_SIZE_DEF,
  parameter int QUEUE_DEPTH = dsh_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata, lowest bit up: action[1:0], read_x[8:2], read_z[15:9], rand_centre[23:16],
  // rand_top[31:24], rand_bottom[39:32], rand_left[47:40], rand_right[55:48]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,
  // out_tdata, lowest bit up: height[15:0], done_res[16], zero fill[23:17]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);
  import dsh_pkg::*;

  `include "diamond_square_heightmap_defines.svh"

  localparam int CW     = $clog2(GRID_SIZE);
  localparam int NPTS   = GRID_SIZE * GRID_SIZE;
  localparam int AW     = $clog2(NPTS);
  localparam int QAW    = $clog2(QUEUE_DEPTH);
  localparam int QCW    = $clog2(QUEUE_DEPTH + 1);
  localparam int QEW    = 4 * CW + HEIGHT_W;
  localparam int GW     = HEIGHT_W + 1;

  // Controller states.
  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_CORNER = 4'd1;
  localparam logic [3:0] S_SEED   = 4'd2;
  localparam logic [3:0] S_IDLE   = 4'd3;
  localparam logic [3:0] S_RDW    = 4'd4;
  localparam logic [3:0] S_QW     = 4'd5;
  localparam logic [3:0] S_CRN    = 4'd6;
  localparam logic [3:0] S_PTR    = 4'd7;
  localparam logic [3:0] S_PTW    = 4'd8;
  localparam logic [3:0] S_PUSH   = 4'd9;
  localparam logic [3:0] S_RES    = 4'd10;

  localparam logic [CW-1:0] EDGE_C = CW'(GRID_SIZE - 1);

  // Unpacked request fields.
  logic [1:0]            in_action;
  logic [COORD_IN_W-1:0] in_read_x;
  logic [COORD_IN_W-1:0] in_read_z;
  assign in_action = in_tdata[1:0];
  assign in_read_x = in_tdata[8:2];
  assign in_read_z = in_tdata[15:9];

  // Memories: grid holds {written flag, height}; queue holds {base, b, r, t, l}.
  logic [GW-1:0]  grid_mem [0:NPTS-1];
  logic [QEW-1:0] queue_mem [0:QUEUE_DEPTH-1];

  logic           g_we;
  logic [AW-1:0]  g_addr;
  logic [GW-1:0]  g_wd;
  logic [GW-1:0]  g_q_r;
  logic           q_we;
  logic [QAW-1:0] q_addr;
  logic [QEW-1:0] q_wd;
  logic [QEW-1:0] q_q_r;

  always_ff @(posedge clk) begin
    if (g_we) begin
      grid_mem[g_addr] <= g_wd;
    end
    g_q_r <= grid_mem[g_addr];
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      queue_mem[q_addr] <= q_wd;
    end
    q_q_r <= queue_mem[q_addr];
  end

  // Control and working registers.
  logic [3:0]            state_r, state_nxt;
  logic [2:0]            sub_r, sub_nxt;
  logic [AW-1:0]         clr_r, clr_nxt;
  logic                  restart_r, restart_nxt;
  logic [QAW-1:0]        head_r, head_nxt;
  logic [QCW-1:0]        count_r, count_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic signed [15:0]    min_r, min_nxt;
  logic signed [15:0]    max_r, max_nxt;
  logic signed [15:0]    fill_r, fill_nxt;
  logic signed [15:0]    mid_r, mid_nxt;
  logic signed [15:0]    res_r, res_nxt;
  logic signed [15:0]    out_height_r, out_height_nxt;
  logic                  out_done_r, out_done_nxt;
  logic [CW-1:0]         l_r, l_nxt, t_r, t_nxt, rr_r, rr_nxt, b_r, b_nxt;
  logic signed [15:0]    base_r, base_nxt;
  logic signed [15:0]    nb_r, nb_nxt;
  logic signed [33:0]    prod_r, prod_nxt;
  logic signed [15:0]    crn_r [0:3];
  logic signed [15:0]    crn_nxt [0:3];
  logic signed [RAND_W-1:0] rnd_r [0:4];
  logic signed [RAND_W-1:0] rnd_nxt [0:4];

  // Derived region values.
  logic [CW-1:0]      cx, cz;
  logic [CW-1:0]      pt_x, pt_z;
  logic [CW-1:0]      cr_x, cr_z;
  logic signed [17:0] pt_sum;
  logic signed [17:0] mul_a;
  logic signed [15:0] pt_height;
  logic signed [33:0] nb_round;
  logic [QAW:0]       tail_sum;
  logic [QAW-1:0]     tail;
  logic               q_full;
  logic               rd_inside;
  logic signed [16:0] mm_sum;
  logic               out_free;

  function automatic logic [AW-1:0] gaddr(input logic [AW-1:0] x, input logic [AW-1:0] z);
    return AW'(z * AW'(GRID_SIZE)) + x;
  endfunction

  assign cx = CW'(({1'b0, l_r} + {1'b0, rr_r}) >> 1);
  assign cz = CW'(({1'b0, t_r} + {1'b0, b_r}) >> 1);

  // Point order within a step: centre, top, bottom, left, right.
  always_comb begin
    case (sub_r)
      3'd0: begin pt_x = cx;   pt_z = cz;  pt_sum = 18'(crn_r[0]) + 18'(crn_r[1])
                                               + 18'(crn_r[2]) + 18'(crn_r[3]); end
      3'd1: begin pt_x = cx;   pt_z = t_r; pt_sum = 18'(crn_r[0]) + 18'(crn_r[1]); end
      3'd2: begin pt_x = cx;   pt_z = b_r; pt_sum = 18'(crn_r[2]) + 18'(crn_r[3]); end
      3'd3: begin pt_x = l_r;  pt_z = cz;  pt_sum = 18'(crn_r[0]) + 18'(crn_r[2]); end
      3'd4: begin pt_x = rr_r; pt_z = cz;  pt_sum = 18'(crn_r[1]) + 18'(crn_r[3]); end
      default: begin pt_x = cx; pt_z = cz; pt_sum = '0; end
    endcase
  end

  // Corner order: top-left, top-right, bottom-left, bottom-right.
  always_comb begin
    case (sub_r[1:0])
      2'd0:    begin cr_x = l_r;  cr_z = t_r; end
      2'd1:    begin cr_x = rr_r; cr_z = t_r; end
      2'd2:    begin cr_x = l_r;  cr_z = b_r; end
      default: begin cr_x = rr_r; cr_z = b_r; end
    endcase
  end

  dsh_calc u_calc (
    .sum_i    (pt_sum),
    .centre_i (sub_r == 3'd0),
    .prod_i   (prod_r[23:0]),
    .height_o (pt_height)
  );

  assign nb_round  = (prod_r + 34'sd32768) >>> 16;
  assign tail_sum  = (QAW+1)'(head_r) + (QAW+1)'(count_r);
  assign tail      = (tail_sum >= (QAW+1)'(QUEUE_DEPTH)) ?
                     QAW'(tail_sum - (QAW+1)'(QUEUE_DEPTH)) : QAW'(tail_sum);
  assign q_full    = (count_r >= QCW'(QUEUE_DEPTH));
  assign rd_inside = (int'(in_read_x) < GRID_SIZE) && (int'(in_read_z) < GRID_SIZE);
  assign mm_sum    = 17'(min_r) + 17'(max_r);
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    sub_nxt       = sub_r;
    clr_nxt       = clr_r;
    restart_nxt   = restart_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    fill_nxt      = fill_r;
    mid_nxt       = mid_r;
    res_nxt       = res_r;
    l_nxt         = l_r;
    t_nxt         = t_r;
    rr_nxt        = rr_r;
    b_nxt         = b_r;
    base_nxt      = base_r;
    nb_nxt        = nb_r;
    prod_nxt      = prod_r;
    crn_nxt       = crn_r;
    rnd_nxt       = rnd_r;
    out_height_nxt = out_height_r;
    out_done_nxt  = out_done_r;
    out_valid_nxt = out_valid_r && !out_tready;
    mul_a         = 18'(rnd_r[sub_r]);
    g_we          = 1'b0;
    g_addr        = gaddr(AW'(pt_x), AW'(pt_z));
    g_wd          = {1'b1, pt_height};
    q_we          = 1'b0;
    q_addr        = head_r;
    q_wd          = {nb_r, b_r, rr_r, t_r, l_r};

    if (cfg_we) begin
      if (cfg_index == CFG_MIN) begin
        min_nxt = signed'(cfg_wdata);
      end else begin
        max_nxt = signed'(cfg_wdata);
      end
    end

    case (state_r)
      S_CLR: begin
        g_we   = 1'b1;
        g_addr = clr_r;
        g_wd   = {1'b0, fill_r};
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(NPTS - 1)) begin
          sub_nxt   = '0;
          state_nxt = restart_r ? S_CORNER : S_IDLE;
        end
      end
      S_CORNER: begin
        // The sweep left every flag clear, so the corners are written outright.
        g_we = 1'b1;
        g_wd = {1'b1, mid_r};
        g_addr = gaddr(AW'(sub_r[0] ? EDGE_C : '0), AW'(sub_r[1] ? EDGE_C : '0));
        sub_nxt = sub_r + 1'b1;
        if (sub_r == 3'd3) begin
          state_nxt = S_SEED;
        end
      end
      S_SEED: begin
        q_we      = 1'b1;
        q_addr    = '0;
        q_wd      = {mid_r, EDGE_C, EDGE_C, CW'(0), CW'(0)};
        count_nxt = QCW'(1);
        res_nxt   = '0;
        state_nxt = S_RES;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          rnd_nxt[0] = in_tdata[23:16];
          rnd_nxt[1] = in_tdata[31:24];
          rnd_nxt[2] = in_tdata[39:32];
          rnd_nxt[3] = in_tdata[47:40];
          rnd_nxt[4] = in_tdata[55:48];
          res_nxt    = '0;
          state_nxt  = S_RES;
          case (in_action)
            ACT_STEP: begin
              if (count_r != '0) begin
                // Pop now; the slot is free before any push of this step.
                q_addr    = head_r;
                head_nxt  = (head_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
                count_nxt = count_r - 1'b1;
                state_nxt = S_QW;
              end
            end
            ACT_READ: begin
              if (rd_inside) begin
                g_addr    = gaddr(AW'(in_read_x), AW'(in_read_z));
                state_nxt = S_RDW;
              end
            end
            ACT_RESTART: begin
              fill_nxt    = min_r;
              mid_nxt     = 16'(mm_sum >>> 1);
              head_nxt    = '0;
              count_nxt   = '0;
              clr_nxt     = '0;
              restart_nxt = 1'b1;
              state_nxt   = S_CLR;
            end
            default: begin
              state_nxt = S_RES;
            end
          endcase
        end
      end
      S_RDW: begin
        res_nxt   = signed'(g_q_r[HEIGHT_W-1:0]);
        state_nxt = S_RES;
      end
      S_QW: begin
        {base_nxt, b_nxt, rr_nxt, t_nxt, l_nxt} = q_q_r;
        sub_nxt   = '0;
        state_nxt = S_CRN;
      end
      S_CRN: begin
        g_addr = gaddr(AW'(cr_x), AW'(cr_z));
        if (sub_r == 3'd0) begin
          mul_a    = 18'(SCALE_Q16);
          prod_nxt = 34'(mul_a * base_r);
        end
        if (sub_r == 3'd1) begin
          nb_nxt = sat16(20'(nb_round));
        end
        case (sub_r)
          3'd1:    crn_nxt[0] = signed'(g_q_r[HEIGHT_W-1:0]);
          3'd2:    crn_nxt[1] = signed'(g_q_r[HEIGHT_W-1:0]);
          3'd3:    crn_nxt[2] = signed'(g_q_r[HEIGHT_W-1:0]);
          3'd4:    crn_nxt[3] = signed'(g_q_r[HEIGHT_W-1:0]);
          default: crn_nxt[0] = crn_r[0];
        endcase
        sub_nxt = sub_r + 1'b1;
        if (sub_r == 3'd4) begin
          sub_nxt   = '0;
          state_nxt = S_PTR;
        end
      end
      S_PTR: begin
        // Fetch the flag of the point while its offset product is formed.
        prod_nxt  = 34'(mul_a * base_r);
        state_nxt = S_PTW;
      end
      S_PTW: begin
        g_we    = !g_q_r[GW-1];
        sub_nxt = sub_r + 1'b1;
        state_nxt = S_PTR;
        if (sub_r == 3'd4) begin
          sub_nxt   = '0;
          state_nxt = ((rr_r > l_r) && ((rr_r - l_r) > CW'(2))) ? S_PUSH : S_RES;
        end
      end
      S_PUSH: begin
        // Quadrants in order top-left, top-right, bottom-left, bottom-right.
        q_addr = tail;
        q_we   = !q_full;
        case (sub_r[1:0])
          2'd0:    q_wd = {nb_r, cz,  cx,   t_r, l_r};
          2'd1:    q_wd = {nb_r, cz,  rr_r, t_r, cx};
          2'd2:    q_wd = {nb_r, b_r, cx,   cz,  l_r};
          default: q_wd = {nb_r, b_r, rr_r, cz,  cx};
        endcase
        if (!q_full) begin
          count_nxt = count_r + 1'b1;
        end
        sub_nxt = sub_r + 1'b1;
        if (sub_r == 3'd3) begin
          state_nxt = S_RES;
        end
      end
      S_RES: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_height_nxt = res_r;
          out_done_nxt   = (count_r == '0);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      sub_r       <= '0;
      clr_r       <= '0;
      restart_r   <= 1'b0;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      min_r       <= 16'sd0;
      max_r       <= 16'sd25600;
      fill_r      <= 16'sd0;
    end else begin
      state_r     <= state_nxt;
      sub_r       <= sub_nxt;
      clr_r       <= clr_nxt;
      restart_r   <= restart_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      fill_r      <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mid_r        <= mid_nxt;
    res_r        <= res_nxt;
    l_r          <= l_nxt;
    t_r          <= t_nxt;
    rr_r         <= rr_nxt;
    b_r          <= b_nxt;
    base_r       <= base_nxt;
    nb_r         <= nb_nxt;
    prod_r       <= prod_nxt;
    crn_r        <= crn_nxt;
    rnd_r        <= rnd_nxt;
    out_height_r <= out_height_nxt;
    out_done_r   <= out_done_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_done_r, out_height_r};

  // The queue fill level never passes its depth.
  `DSH_ASSERT_NOW(a_count_bound, 1'b1, count_r <= QCW'(QUEUE_DEPTH), "queue count overflow")
  // A restart request empties the queue on the next cycle.
  `DSH_ASSERT_NEXT(a_restart_empty, in_tvalid && in_tready && in_action == ACT_RESTART,
                   count_r == '0, "restart left regions queued")
  // A step on a non-empty queue pops exactly one region.
  `DSH_ASSERT_NEXT(a_step_pop,
                   in_tvalid && in_tready && in_action == ACT_STEP && count_r != '0,
                   count_r == $past(count_r) - 1'b1, "step did not pop one region")
  // A point update never overwrites a point that already holds a value.
  `DSH_ASSERT_NOW(a_soft_write, state_r == S_PTW && g_we, !g_q_r[GW-1],
                  "written point overwritten")

endmodule

// ===== rtl/dsh_calc.sv =====
// Height arithmetic for one centre or edge midpoint of a region.
module dsh_calc (
  input  logic signed [17:0] sum_i,
  input  logic               centre_i,
  input  logic signed [23:0] prod_i,
  output logic signed [15:0] height_o
);
  import dsh_pkg::*;

  logic signed [17:0] avg;
  logic signed [24:0] rsum;
  logic signed [17:0] rnd;
  logic signed [19:0] v;

  // The centre averages four corners and subtracts twice the scaled offset;
  // an edge averages two corners and adds the offset. Rounding is half up.
  always_comb begin
    avg  = centre_i ? (sum_i >>> 2) : (sum_i >>> 1);
    rsum = 25'(prod_i) + (centre_i ? 25'sd64 : 25'sd128);
    rnd  = centre_i ? 18'(rsum >>> 7) : 18'(rsum >>> 8);
    v    = centre_i ? (20'(avg) - 20'(rnd)) : (20'(avg) + 20'(rnd));
    height_o = sat16(v);
  end

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench of the diamond-square height map generator.
`timescale 1ns / 100ps

module testbench;
  import dsh_pkg::*;

  localparam int GRID = 65;
  localparam int QDEPTH = 1024;
  localparam int NPOINTS = GRID * GRID;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  // Idle cycles allowed after the last result before the block counts as quiet.
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int RANDOM_ITEMS = 480;
  localparam int PHASES = 6;

  // One request as the block sees it, and one result.
  typedef struct packed {
    logic signed [7:0] rand_right;
    logic signed [7:0] rand_left;
    logic signed [7:0] rand_bottom;
    logic signed [7:0] rand_top;
    logic signed [7:0] rand_centre;
    logic [6:0] read_z;
    logic [6:0] read_x;
    logic [1:0] action;
  } request_t;

  typedef struct packed {
    logic signed [15:0] height;
    logic done;
  } result_t;

  // A row of the directed table: the request, and a typed result when one is given.
  typedef struct {
    request_t req;
    bit typed;
    result_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [55:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_MIN;
  logic [15:0] cfg_wdata = '0;

  always #5 clk = ~clk;

  diamond_square_heightmap dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // The predictor keeps its own copy of the grid, the written flags and the region queue.
  logic signed [15:0] terrain[NPOINTS];
  bit touched[NPOINTS];
  int region_l[QDEPTH], region_t[QDEPTH], region_r[QDEPTH], region_b[QDEPTH];
  logic signed [15:0] region_base[QDEPTH];
  int region_head, region_count;
  logic signed [15:0] floor_level, ceiling_level;

  result_t pending_results[$];
  int mismatches = 0;
  bit hold_request = 1'b0;

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  // Rounds to nearest with ties toward plus infinity; >>> on a signed value floors.
  function automatic longint round_shift(longint v, int k);
    return (v + (64'sd1 <<< (k - 1))) >>> k;
  endfunction

  function automatic void plant(int x, int z, logic signed [15:0] h);
    int idx;
    idx = z * GRID + x;
    if (x < GRID && z < GRID && !touched[idx]) begin
      touched[idx] = 1'b1;
      terrain[idx] = h;
    end
  endfunction

  function automatic void enqueue_region(int l, int t, int r, int b, logic signed [15:0] base);
    int slot;
    if (region_count < QDEPTH) begin
      slot = (region_head + region_count) % QDEPTH;
      region_l[slot] = l;
      region_t[slot] = t;
      region_r[slot] = r;
      region_b[slot] = b;
      region_base[slot] = base;
      region_count++;
    end
  endfunction

  function automatic void restart_terrain();
    logic signed [15:0] mid;
    mid = 16'((longint'(floor_level) + longint'(ceiling_level)) >>> 1);
    for (int i = 0; i < NPOINTS; i++) begin
      terrain[i] = floor_level;
      touched[i] = 1'b0;
    end
    region_head = 0;
    region_count = 0;
    plant(0, 0, mid);
    plant(0, GRID - 1, mid);
    plant(GRID - 1, 0, mid);
    plant(GRID - 1, GRID - 1, mid);
    enqueue_region(0, 0, GRID - 1, GRID - 1, mid);
  endfunction

  // Pops the oldest region, fills its centre and edge midpoints and, if it still splits, queues its quadrants.
  function automatic void subdivide(request_t q);
    int l, t, r, b, cx, cz;
    longint tl, tr, bl, br, base;
    logic signed [15:0] child;
    if (region_count == 0) return;
    l = region_l[region_head];
    t = region_t[region_head];
    r = region_r[region_head];
    b = region_b[region_head];
    base = region_base[region_head];
    region_head = (region_head + 1) % QDEPTH;
    region_count--;
    if (l >= GRID || t >= GRID || r >= GRID || b >= GRID) return;
    cx = (l + r) >> 1;
    cz = (t + b) >> 1;
    tl = terrain[t * GRID + l];
    tr = terrain[t * GRID + r];
    bl = terrain[b * GRID + l];
    br = terrain[b * GRID + r];
    plant(cx, cz, clamp16(((tl + tr + bl + br) >>> 2)
                          - round_shift(longint'(q.rand_centre) * base, 7)));
    plant(cx, t, clamp16(((tl + tr) >>> 1) + round_shift(longint'(q.rand_top) * base, 8)));
    plant(cx, b, clamp16(((bl + br) >>> 1) + round_shift(longint'(q.rand_bottom) * base, 8)));
    plant(l, cz, clamp16(((tl + bl) >>> 1) + round_shift(longint'(q.rand_left) * base, 8)));
    plant(r, cz, clamp16(((tr + br) >>> 1) + round_shift(longint'(q.rand_right) * base, 8)));
    if (r - l > 2) begin
      child = clamp16(round_shift(base * 38968, 16));
      enqueue_region(l, t, cx, cz, child);
      enqueue_region(cx, t, r, cz, child);
      enqueue_region(l, cz, cx, b, child);
      enqueue_region(cx, cz, r, b, child);
    end
  endfunction

  function automatic result_t predict_heightmap(request_t q);
    result_t res;
    res.height = '0;
    case (q.action)
      ACT_STEP: begin
        subdivide(q);
      end
      ACT_READ: begin
        if (q.read_x < GRID && q.read_z < GRID) res.height = terrain[q.read_z * GRID + q.read_x];
      end
      ACT_RESTART: begin
        restart_terrain();
      end
      default: begin
      end
    endcase
    res.done = (region_count == 0);
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Offers one request, waits for the handshake and records what it should return.
  // The valid is lowered only when a gap follows, so it never drops and rises in one step.
  task automatic offer_request(request_t q, bit typed, result_t typed_res, int gap);
    result_t res;
    in_tdata <= q;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    res = predict_heightmap(q);
    pending_results.push_back(typed ? typed_res : res);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Lets every result drain, then a few idle cycles, so that a register write is safe.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The write enable is lowered after each write and stays low until the next one, so
  // back-to-back writes never drive it twice in one step.
  task automatic write_register(logic idx, logic signed [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MIN) floor_level = value;
    else ceiling_level = value;
    @(posedge clk);
  endtask

  function automatic request_t make_request(logic [1:0] act, int x, int z,
                                            int rc, int rt, int rb, int rl, int rr);
    request_t q;
    q.action = act;
    q.read_x = 7'(x);
    q.read_z = 7'(z);
    q.rand_centre = 8'(rc);
    q.rand_top = 8'(rt);
    q.rand_bottom = 8'(rb);
    q.rand_left = 8'(rl);
    q.rand_right = 8'(rr);
    return q;
  endfunction

  // Random request: mostly steps with random offsets and reads of grid points, with a
  // few restarts, unused actions and reads outside the grid mixed in.
  function automatic request_t random_request();
    request_t q;
    int pick;
    q = request_t'(56'({$urandom, $urandom}));
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      q.action = ACT_STEP;
    end else if (pick < 95) begin
      q.action = ACT_READ;
      if ($urandom_range(0, 9) != 0) begin
        q.read_x = 7'($urandom_range(0, GRID - 1));
        q.read_z = 7'($urandom_range(0, GRID - 1));
      end
    end else if (pick < 97) begin
      q.action = ACT_RESTART;
    end else begin
      q.action = ACT_UNUSED;
    end
    return q;
  endfunction

  // The result side: random stalls before each result, and one long hold-off on request.
  initial begin : result_side
    result_t got, want;
    int stall;
    forever begin
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (out_tvalid !== 1'b1) @(posedge clk);
      got = result_t'({out_tdata[15:0], out_tdata[16]});
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, height", got.height, 0);
      end else begin
        want = pending_results.pop_front();
        if (got.height !== want.height) report_mismatch("height", got.height, want.height);
        if (got.done !== want.done) report_mismatch("done", got.done, want.done);
      end
    end
  end

  initial begin : stimulus
    stim_row_t directed[$];
    stim_row_t row;
    logic signed [15:0] phase_min[PHASES], phase_max[PHASES];
    int gap;

    // Model state after reset.
    for (int i = 0; i < NPOINTS; i++) begin
      terrain[i] = '0;
      touched[i] = 1'b0;
    end
    region_head = 0;
    region_count = 0;
    floor_level = 16'sd0;
    ceiling_level = 16'sd25600;

    // Register settings per phase: the reset values, the extremes, and a random pair.
    phase_min = '{16'sd0, -16'sd32768, 16'sh7fff, -16'sd32768, 16'sh7fff, 16'sd0};
    phase_max = '{16'sd25600, 16'sh7fff, 16'sh7fff, -16'sd32768, -16'sd32768, 16'sd0};
    phase_min[5] = 16'($urandom);
    phase_max[5] = 16'($urandom);

    // Directed table. Right after reset the queue is empty and the grid is zero, and a
    // restart puts the midpoint of the default range (12800) on the corners.
    directed.push_back('{make_request(ACT_STEP, 0, 0, 0, 0, 0, 0, 0), 1, '{16'sd0, 1'b1}});
    directed.push_back('{make_request(ACT_READ, 0, 0, 0, 0, 0, 0, 0), 1, '{16'sd0, 1'b1}});
    directed.push_back('{make_request(ACT_READ, 64, 64, 0, 0, 0, 0, 0), 1, '{16'sd0, 1'b1}});
    directed.push_back('{make_request(ACT_READ, 127, 127, -1, -1, -1, -1, -1), 1,
                         '{16'sd0, 1'b1}});
    directed.push_back('{make_request(ACT_READ, 65, 0, 0, 0, 0, 0, 0), 1, '{16'sd0, 1'b1}});
    directed.push_back('{make_request(ACT_READ, 0, 65, 0, 0, 0, 0, 0), 1, '{16'sd0, 1'b1}});
    directed.push_back('{make_request(ACT_UNUSED, 5, 5, 0, 0, 0, 0, 0), 1, '{16'sd0, 1'b1}});
    directed.push_back('{make_request(ACT_RESTART, 0, 0, 0, 0, 0, 0, 0), 1,
                         '{16'sd0, 1'b0}});
    directed.push_back('{make_request(ACT_READ, 0, 0, 0, 0, 0, 0, 0), 1,
                         '{16'sd12800, 1'b0}});
    directed.push_back('{make_request(ACT_READ, 64, 0, 0, 0, 0, 0, 0), 1,
                         '{16'sd12800, 1'b0}});
    directed.push_back('{make_request(ACT_READ, 0, 64, 0, 0, 0, 0, 0), 1,
                         '{16'sd12800, 1'b0}});
    directed.push_back('{make_request(ACT_READ, 64, 64, 0, 0, 0, 0, 0), 1,
                         '{16'sd12800, 1'b0}});
    directed.push_back('{make_request(ACT_READ, 1, 1, 0, 0, 0, 0, 0), 1, '{16'sd0, 1'b0}});
    directed.push_back('{make_request(ACT_STEP, 0, 0, 127, -128, -128, -128, -128), 0, '{0, 0}});
    directed.push_back('{make_request(ACT_READ, 32, 32, 0, 0, 0, 0, 0), 0, '{0, 0}});
    directed.push_back('{make_request(ACT_READ, 32, 0, 0, 0, 0, 0, 0), 0, '{0, 0}});
    directed.push_back('{make_request(ACT_READ, 0, 32, 0, 0, 0, 0, 0), 0, '{0, 0}});
    directed.push_back('{make_request(ACT_STEP, 0, 0, -128, 127, 127, 127, 127), 0, '{0, 0}});
    directed.push_back('{make_request(ACT_STEP, 0, 0, 0, 0, 0, 0, 0), 0, '{0, 0}});
    directed.push_back('{make_request(ACT_READ, 16, 16, 0, 0, 0, 0, 0), 0, '{0, 0}});
    directed.push_back('{make_request(ACT_READ, 48, 16, 0, 0, 0, 0, 0), 0, '{0, 0}});
    directed.push_back('{make_request(ACT_READ, 32, 16, 0, 0, 0, 0, 0), 0, '{0, 0}});
    directed.push_back('{make_request(ACT_RESTART, 0, 0, 0, 0, 0, 0, 0), 0, '{0, 0}});

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      row = directed[i];
      gap = $urandom_range(0, 5);
      offer_request(row.req, row.typed, row.res, gap);
    end

    // Random phases: each starts idle with new register values and a restart, then
    // mostly walks the region queue while reading points back.
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      write_register(CFG_MIN, phase_min[p]);
      write_register(CFG_MAX, phase_max[p]);
      offer_request(make_request(ACT_RESTART, 0, 0, 0, 0, 0, 0, 0), 0, '{0, 0}, 0);
      // In the second phase the result side holds off while requests keep coming.
      if (p == 1) hold_request = 1'b1;
      for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        // Stretches without any gap alternate with randomly idling ones.
        gap = (n % 40 < 10) ? 0 : $urandom_range(0, 5);
        offer_request(random_request(), 0, '{0, 0}, gap);
      end
    end

    drain_results();
    if (mismatches == 0) begin
      $display("diamond_square_heightmap test passed");
    end else begin
      $display("diamond_square_heightmap test failed");
    end
    $finish;
  end

  // Guard against a hang: well beyond the slowest correct run, even if every request
  // were a restart under the longest stalls.
  initial begin : watchdog
    #100_000_000;
    $display("diamond_square_heightmap test failed");
    $finish;
  end

endmodule
